// ===== sv/rc4_pkg.sv =====
// Shared constants and controller/datapath interface types for the RC4 block.
package rc4_pkg;

  localparam int TABLE_SIZE        = 256;
  localparam int DEF_MAX_KEY_BYTES = 256;
  localparam int KEY_LEN_W         = 9;
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 9'd16;

  // command codes carried in s_tuser
  localparam logic [1:0] CMD_LOAD_KEY = 2'd0;
  localparam logic [1:0] CMD_SCHEDULE = 2'd1;
  localparam logic [1:0] CMD_CRYPT    = 2'd2;

  // datapath operations issued by the controller
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD_KEY = 4'd1;
  localparam logic [OP_W-1:0] OP_SCH_INIT = 4'd2;
  localparam logic [OP_W-1:0] OP_SCH_RD   = 4'd3;
  localparam logic [OP_W-1:0] OP_SCH_J    = 4'd4;
  localparam logic [OP_W-1:0] OP_SCH_WK   = 4'd5;
  localparam logic [OP_W-1:0] OP_SCH_WJ   = 4'd6;
  localparam logic [OP_W-1:0] OP_CR_RI    = 4'd7;
  localparam logic [OP_W-1:0] OP_CR_J     = 4'd8;
  localparam logic [OP_W-1:0] OP_CR_T     = 4'd9;
  localparam logic [OP_W-1:0] OP_CR_WJ    = 4'd10;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic sch_last;   // schedule step counter at its final step
    logic out_stall;  // result register full and not being taken
  } dp_status_t;

endpackage

// ===== sv/rc4_ctrl.sv =====
// Sequencer for key load, key scheduling and crypt transactions.
module rc4_ctrl
  import rc4_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [1:0] s_tuser,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCH_RD = 3'd1;
  localparam logic [2:0] ST_SCH_J  = 3'd2;
  localparam logic [2:0] ST_SCH_WK = 3'd3;
  localparam logic [2:0] ST_SCH_WJ = 3'd4;
  localparam logic [2:0] ST_CR_J   = 3'd5;
  localparam logic [2:0] ST_CR_T   = 3'd6;
  localparam logic [2:0] ST_CR_WJ  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          case (s_tuser)
            CMD_LOAD_KEY: cmd.op = OP_LOAD_KEY;
            CMD_SCHEDULE: begin
              cmd.op     = OP_SCH_INIT;
              state_next = ST_SCH_RD;
            end
            CMD_CRYPT: begin
              cmd.op     = OP_CR_RI;
              state_next = ST_CR_J;
            end
            default: cmd.op = OP_NONE;
          endcase
        end
      end
      ST_SCH_RD: begin
        cmd.op     = OP_SCH_RD;
        state_next = ST_SCH_J;
      end
      ST_SCH_J: begin
        cmd.op     = OP_SCH_J;
        state_next = ST_SCH_WK;
      end
      ST_SCH_WK: begin
        cmd.op     = OP_SCH_WK;
        state_next = ST_SCH_WJ;
      end
      ST_SCH_WJ: begin
        cmd.op     = OP_SCH_WJ;
        state_next = status.sch_last ? ST_IDLE : ST_SCH_RD;
      end
      ST_CR_J: begin
        cmd.op     = OP_CR_J;
        state_next = ST_CR_T;
      end
      ST_CR_T: begin
        cmd.op     = OP_CR_T;
        state_next = ST_CR_WJ;
      end
      ST_CR_WJ: begin
        // hold here until the result register can take the byte
        if (!status.out_stall) begin
          cmd.op     = OP_CR_WJ;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== sv/rc4_dp.sv =====
// Datapath: permutation table, key store, indices and result register.
module rc4_dp
  import rc4_pkg::*;
#(
  parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  input  logic [15:0]          s_tdata,   // [7:0] key_index, [15:8] data_byte
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [15:0]          m_tdata,   // [7:0] out_byte, [15:8] keystream_byte
  input  logic                 cfg_wr_en,
  input  logic [KEY_LEN_W-1:0] cfg_wr_data
);

  localparam int KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam logic [KEY_LEN_W-1:0] MAX_LEN = KEY_LEN_W'(MAX_KEY_BYTES);

  logic [7:0] key_index;
  logic [7:0] data_byte;
  assign key_index = s_tdata[7:0];
  assign data_byte = s_tdata[15:8];

  // permutation table; an entry never written since the last schedule reads as its index
  logic [7:0]            perm_mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] perm_vld;
  logic [7:0]            perm_raddr;
  logic [7:0]            perm_raddr_q;
  logic [7:0]            perm_rdata_q;
  logic                  perm_rvld_q;
  logic                  perm_we;
  logic [7:0]            perm_waddr;
  logic [7:0]            perm_wdata;
  logic [7:0]            perm_eff;

  // key store; unwritten entries read as zero
  logic [7:0]               key_mem [MAX_KEY_BYTES];
  logic [MAX_KEY_BYTES-1:0] key_vld;
  logic [7:0]               key_rdata_q;
  logic                     key_rvld_q;
  logic                     key_we;
  logic [7:0]               key_eff;

  logic [KEY_LEN_W-1:0] key_length;
  logic [KEY_LEN_W-1:0] eff_len;
  logic [KEY_LEN_W-1:0] pos_inc;

  logic [7:0]     index_i;
  logic [7:0]     index_j;
  logic [7:0]     sch_k;
  logic [KAW-1:0] sch_pos;
  logic [7:0]     s_a;      // S[i] in crypt, S[k] in schedule
  logic [7:0]     s_b;      // S[j] in crypt
  logic [7:0]     t_addr;
  logic [7:0]     data_q;

  logic [7:0] i_inc;
  logic [7:0] j_crypt;
  logic [7:0] j_sched;
  logic [7:0] t_sum;
  logic [7:0] ks;

  assign perm_eff = perm_rvld_q ? perm_rdata_q : perm_raddr_q;
  assign key_eff  = key_rvld_q ? key_rdata_q : 8'd0;

  assign i_inc   = 8'(index_i + 8'd1);
  assign j_crypt = 8'(index_j + perm_eff);
  assign j_sched = 8'(index_j + perm_eff + key_eff);
  assign t_sum   = 8'(s_a + perm_eff);

  // after the swap S[j] holds old S[i] and S[i] holds old S[j]
  assign ks = (t_addr == index_j) ? s_a :
              (t_addr == index_i) ? s_b : perm_eff;

  assign key_we = (cmd.op == OP_LOAD_KEY) && ({1'b0, key_index} < MAX_LEN);

  always_comb begin
    if (key_length == '0) begin
      eff_len = KEY_LEN_W'(1);
    end else if (key_length > MAX_LEN) begin
      eff_len = MAX_LEN;
    end else begin
      eff_len = key_length;
    end
  end

  assign pos_inc = KEY_LEN_W'(sch_pos) + KEY_LEN_W'(1);

  always_comb begin
    // keep re-reading the last address so a stalled crypt keeps S[S[i]+S[j]]
    perm_raddr = perm_raddr_q;
    perm_we    = 1'b0;
    perm_waddr = index_i;
    perm_wdata = perm_eff;
    case (cmd.op)
      OP_SCH_RD: perm_raddr = sch_k;
      OP_SCH_J:  perm_raddr = j_sched;
      OP_SCH_WK: begin
        perm_we    = 1'b1;
        perm_waddr = sch_k;
        perm_wdata = perm_eff;
      end
      OP_SCH_WJ: begin
        perm_we    = 1'b1;
        perm_waddr = index_j;
        perm_wdata = s_a;
      end
      OP_CR_RI:  perm_raddr = i_inc;
      OP_CR_J:   perm_raddr = j_crypt;
      OP_CR_T: begin
        perm_raddr = t_sum;
        perm_we    = 1'b1;
        perm_waddr = index_i;
        perm_wdata = perm_eff;
      end
      OP_CR_WJ: begin
        perm_we    = 1'b1;
        perm_waddr = index_j;
        perm_wdata = s_a;
      end
      default: perm_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (perm_we) begin
      perm_mem[perm_waddr] <= perm_wdata;
    end
    perm_rdata_q <= perm_mem[perm_raddr];
    perm_rvld_q  <= perm_vld[perm_raddr];
    perm_raddr_q <= perm_raddr;
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_index[KAW-1:0]] <= data_byte;
    end
    key_rdata_q <= key_mem[sch_pos];
    key_rvld_q  <= key_vld[sch_pos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      perm_vld   <= '0;
      key_vld    <= '0;
      key_length <= KEY_LEN_RESET;
      index_i    <= '0;
      index_j    <= '0;
      sch_k      <= '0;
      sch_pos    <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        key_length <= cfg_wr_data;
      end
      if (key_we) begin
        key_vld[key_index[KAW-1:0]] <= 1'b1;
      end
      if (cmd.op == OP_SCH_INIT) begin
        perm_vld <= '0;  // table back to identity
      end else if (perm_we) begin
        perm_vld[perm_waddr] <= 1'b1;
      end
      if (cmd.op == OP_CR_WJ) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (cmd.op)
        OP_SCH_INIT: begin
          sch_k   <= '0;
          sch_pos <= '0;
          index_j <= '0;
        end
        OP_SCH_J: index_j <= j_sched;
        OP_SCH_WJ: begin
          sch_k <= 8'(sch_k + 8'd1);
          if (pos_inc >= eff_len) begin
            sch_pos <= '0;
          end else begin
            sch_pos <= pos_inc[KAW-1:0];
          end
          if (sch_k == 8'hFF) begin
            index_i <= '0;
            index_j <= '0;
          end
        end
        OP_CR_RI: index_i <= i_inc;
        OP_CR_J:  index_j <= j_crypt;
        default: index_i <= index_i;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_SCH_J: s_a <= perm_eff;
      OP_CR_RI: data_q <= data_byte;
      OP_CR_J:  s_a <= perm_eff;
      OP_CR_T: begin
        s_b    <= perm_eff;
        t_addr <= t_sum;
      end
      OP_CR_WJ: m_tdata <= {ks, data_q ^ ks};
      default: s_a <= s_a;
    endcase
  end

  assign status.sch_last  = (sch_k == 8'hFF);
  assign status.out_stall = m_tvalid && !m_tready;

  a_rise_from_crypt: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.op == OP_CR_WJ))
    else $error("result appeared without a finished crypt transaction");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_CR_WJ) |-> (!m_tvalid || m_tready))
    else $error("result register overwritten while stalled");

  a_sched_clears_idx: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_SCH_WJ && sch_k == 8'hFF) |=> (index_i == 8'd0 && index_j == 8'd0))
    else $error("indices not cleared at end of key schedule");

  a_init_restarts: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_SCH_INIT) |=> (sch_k == 8'd0 && perm_vld == '0))
    else $error("key schedule did not restart from identity");

endmodule

// ===== sv/rc4_stream_cipher_top.sv =====
// RC4 stream cipher top level: controller plus datapath.
// Commands arrive on the slave stream, s_tuser selecting load key byte, run key schedule or
// crypt. A key load is taken without leaving idle. A crypt transaction occupies the block
// while it walks the permutation table, which has one read port and one write port:
// read S[i], read S[j], write S[i] while reading S[S[i]+S[j]], write S[j]; the last
// step waits while the result register is still full. A key schedule runs an init step
// and then 256 steps of four table accesses each. The table and key store are usable right
// after reset with no clearing pass. The user must write key_length through cfg_wr_en /
// cfg_wr_data only while the block is idle; the block itself does not enforce this.
module rc4_stream_cipher_top
  import rc4_pkg::*;
#(
  parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [15:0]          s_tdata,     // [7:0] key_index, [15:8] data_byte
  input  logic [1:0]           s_tuser,     // [1:0] command
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [15:0]          m_tdata,     // [7:0] out_byte, [15:8] keystream_byte
  input  logic                 cfg_wr_en,
  input  logic [KEY_LEN_W-1:0] cfg_wr_data  // key_length
);

  dp_cmd_t    cmd;
  dp_status_t status;

  rc4_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .status   (status),
    .cmd      (cmd)
  );

  rc4_dp #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

endmodule

// ===== bench/rc4_stream_cipher_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the RC4 stream cipher against an RC4 predictor.
module rc4_stream_cipher_top_tb;
  import rc4_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int SCHED_CYCLES = 1100;   // one full key schedule plus margin
  localparam int IDLE_PCT = 34;
  localparam int ITEM_TARGET = 1450;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] idx;
    logic [7:0] data;
  } rc4_cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [7:0] ks_byte;
  } cipher_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [15:0]          s_tdata = '0;     // [7:0] key_index, [15:8] data_byte
  logic [1:0]           s_tuser = '0;     // [1:0] command
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [15:0]          m_tdata;          // [7:0] out_byte, [15:8] keystream_byte
  logic                 cfg_wr_en = 1'b0;
  logic [KEY_LEN_W-1:0] cfg_wr_data = '0;

  rc4_stream_cipher_top uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // predictor state
  logic [7:0]           sbox [TABLE_SIZE];
  logic [7:0]           key_mem [TABLE_SIZE];
  logic [7:0]           idx_i, idx_j;
  logic [KEY_LEN_W-1:0] key_len;

  rc4_cmd_t cmd_q[$];
  cipher_t  cipher_q[$];
  rc4_cmd_t on_bus;
  logic     burst = 1'b0;
  int       n_queued = 0, n_taken = 0, n_results = 0, n_errors = 0;
  int       n_sched = 0, n_cfg = 0;

  function automatic int eff_key_len(logic [KEY_LEN_W-1:0] v);
    int n;
    n = int'(v);
    if (n == 0) n = 1;
    if (n > DEF_MAX_KEY_BYTES) n = DEF_MAX_KEY_BYTES;
    return n;
  endfunction

  function void rc4_rekey();
    int n;
    logic [7:0] j, t;
    n = eff_key_len(key_len);
    for (int k = 0; k < TABLE_SIZE; k++) sbox[k[7:0]] = k[7:0];
    j = 8'd0;
    for (int k = 0; k < TABLE_SIZE; k++) begin
      j = j + sbox[k[7:0]] + key_mem[8'(k % n)];
      t = sbox[k[7:0]];
      sbox[k[7:0]] = sbox[j];
      sbox[j] = t;
    end
    idx_i = 8'd0;
    idx_j = 8'd0;
  endfunction

  function void rc4_apply(rc4_cmd_t c);
    logic [7:0] t, sum, ks;
    case (c.cmd)
      CMD_LOAD_KEY: key_mem[c.idx] = c.data;
      CMD_SCHEDULE: begin
        rc4_rekey();
        n_sched++;
      end
      CMD_CRYPT: begin
        idx_i = idx_i + 8'd1;
        idx_j = idx_j + sbox[idx_i];
        t = sbox[idx_i];
        sbox[idx_i] = sbox[idx_j];
        sbox[idx_j] = t;
        sum = sbox[idx_i] + sbox[idx_j];
        ks = sbox[sum];
        cipher_q.push_back('{out_byte: c.data ^ ks, ks_byte: ks});
      end
      default: ;  // unused code: no effect
    endcase
  endfunction

  task automatic push_item(logic [1:0] cmd, logic [7:0] idx, logic [7:0] data);
    cmd_q.push_back('{cmd: cmd, idx: idx, data: data});
    n_queued++;
  endtask

  // Block is idle once every command is taken and every result is back; the trailing
  // wait covers a schedule that produces no result.
  task automatic wait_idle();
    do @(negedge clk);
    while (!(cmd_q.size() == 0 && n_taken == n_queued && cipher_q.size() == 0));
    repeat (SCHED_CYCLES) @(negedge clk);
  endtask

  task automatic write_key_len(logic [KEY_LEN_W-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    key_len = v;
    n_cfg++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        rc4_apply(on_bus);
        n_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (cmd_q.size() > 0 && (burst || $urandom_range(99) >= IDLE_PCT)) begin
          on_bus = cmd_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {on_bus.data, on_bus.idx};
          s_tuser <= on_bus.cmd;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : result_mon
    cipher_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_results++;
        if (cipher_q.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("ERROR: result with none pending: out_byte=%02h keystream_byte=%02h",
                     m_tdata[7:0], m_tdata[15:8]);
        end else begin
          want = cipher_q.pop_front();
          if (m_tdata[7:0] !== want.out_byte) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
              $display("ERROR: result %0d out_byte expected %02h got %02h",
                       n_results, want.out_byte, m_tdata[7:0]);
          end
          if (m_tdata[15:8] !== want.ks_byte) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
              $display("ERROR: result %0d keystream_byte expected %02h got %02h",
                       n_results, want.ks_byte, m_tdata[15:8]);
          end
        end
      end
      m_tready <= burst || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    #4_000_000;
    $display("rc4_stream_cipher_top_tb NOT OK");
    $finish;
  end

  initial begin
    int phase, len, eff, run_len, pick, spin;
    for (int k = 0; k < TABLE_SIZE; k++) begin
      sbox[k[7:0]] = k[7:0];
      key_mem[k[7:0]] = 8'd0;
    end
    idx_i = 8'd0;
    idx_j = 8'd0;
    key_len = KEY_LEN_RESET;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // crypt on the identity table before any schedule, unused code, key store ends
    push_item(CMD_CRYPT, 8'h00, 8'h00);
    push_item(CMD_CRYPT, 8'hFF, 8'hFF);
    push_item(CMD_UNUSED, 8'hFF, 8'hFF);
    push_item(CMD_LOAD_KEY, 8'h00, 8'hFF);
    push_item(CMD_LOAD_KEY, 8'hFF, 8'hFF);
    push_item(CMD_LOAD_KEY, 8'h0F, 8'h00);
    push_item(CMD_LOAD_KEY, 8'h07, 8'h5A);
    push_item(CMD_SCHEDULE, 8'h00, 8'h00);
    push_item(CMD_CRYPT, 8'h00, 8'hFF);
    push_item(CMD_CRYPT, 8'h00, 8'h00);
    push_item(CMD_UNUSED, 8'h00, 8'h00);
    push_item(CMD_CRYPT, 8'h80, 8'hA5);
    wait_idle();
    write_key_len(9'd0);      // zero length acts as one
    push_item(CMD_SCHEDULE, 8'h00, 8'h00);
    push_item(CMD_CRYPT, 8'h00, 8'h3C);
    push_item(CMD_CRYPT, 8'h00, 8'hC3);
    wait_idle();
    write_key_len(9'h1FF);    // clamps to the full key store
    push_item(CMD_SCHEDULE, 8'h00, 8'h00);
    push_item(CMD_CRYPT, 8'h00, 8'h01);
    push_item(CMD_CRYPT, 8'h00, 8'h80);
    wait_idle();
    write_key_len(9'd256);
    push_item(CMD_LOAD_KEY, 8'hFF, 8'h3C);
    push_item(CMD_SCHEDULE, 8'h00, 8'h00);
    push_item(CMD_CRYPT, 8'h00, 8'h77);

    phase = 0;
    while (n_queued < ITEM_TARGET) begin
      wait_idle();
      case (phase)
        0: len = 1;
        1: len = 256;
        2: len = 300;
        3: len = 0;
        default: len = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(1, 24);
      endcase
      burst = (phase == 4);
      write_key_len(len[KEY_LEN_W-1:0]);
      eff = eff_key_len(len[KEY_LEN_W-1:0]);
      // full key rewrite when short or in phase 1; otherwise 8 to 24 bytes on top of the current store
      if (phase == 1 || eff <= 32) begin
        for (int k = 0; k < eff; k++)
          push_item(CMD_LOAD_KEY, k[7:0], 8'($urandom_range(255)));
      end else begin
        spin = $urandom_range(8, 24);
        for (int k = 0; k < spin; k++)
          push_item(CMD_LOAD_KEY, 8'($urandom_range(255)), 8'($urandom_range(255)));
      end
      push_item(CMD_SCHEDULE, 8'($urandom_range(255)), 8'($urandom_range(255)));
      run_len = $urandom_range(30, 90);
      for (int k = 0; k < run_len; k++) begin
        pick = $urandom_range(99);
        if (pick < 84)
          push_item(CMD_CRYPT, 8'($urandom_range(255)), 8'($urandom_range(255)));
        else if (pick < 90)
          push_item(CMD_UNUSED, 8'($urandom_range(255)), 8'($urandom_range(255)));
        else if (pick < 96)
          push_item(CMD_LOAD_KEY, 8'($urandom_range(255)), 8'($urandom_range(255)));
        else if (pick < 98)  // restart keystream
          push_item(CMD_SCHEDULE, 8'($urandom_range(255)), 8'($urandom_range(255)));
        else
          push_item(2'($urandom_range(3)), 8'($urandom_range(255)),
                    8'($urandom_range(255)));
      end
      phase++;
    end

    // drain: all commands taken, then results back or a bounded wait
    do @(negedge clk);
    while (!(cmd_q.size() == 0 && n_taken == n_queued));
    spin = 0;
    while (cipher_q.size() != 0 && spin < 20000) begin
      @(negedge clk);
      spin++;
    end
    burst = 1'b0;
    repeat (SCHED_CYCLES) @(negedge clk);
    if (cipher_q.size() != 0) begin
      $display("ERROR: %0d expected results never arrived", cipher_q.size());
      n_errors += cipher_q.size();
    end

    $display("Sent %0d commands over %0d key_length settings; %0d key schedules run",
             n_taken, n_cfg, n_sched);
    $display("Checked %0d crypt results, %0d field mismatches", n_results, n_errors);
    if (n_errors == 0)
      $display("rc4_stream_cipher_top_tb OK");
    else
      $display("rc4_stream_cipher_top_tb NOT OK");
    $finish;
  end

endmodule
